// ===== rtl/ssram_pkg.sv =====
// Shared types and constants for the serial SRAM slave.
package ssram_pkg;

    // Array geometry.
    localparam int ADDR_BITS  = 15;
    localparam int PAGE_BYTES = 32;
    localparam int PAGE_BITS  = $clog2(PAGE_BYTES);
    localparam int DATA_BITS  = 8;

    // Event codes on the operation field.
    localparam logic [1:0] OP_SELECT   = 2'd0;
    localparam logic [1:0] OP_XFER     = 2'd1;
    localparam logic [1:0] OP_DESELECT = 2'd2;

    // Instruction opcodes.
    localparam logic [7:0] OPC_READ  = 8'h03;
    localparam logic [7:0] OPC_WRITE = 8'h02;
    localparam logic [7:0] OPC_RDSR  = 8'h05;
    localparam logic [7:0] OPC_WRSR  = 8'h01;

    // Mode field of the status register.
    localparam logic [1:0] MODE_BYTE = 2'b00;
    localparam logic [1:0] MODE_SEQ  = 2'b01;
    localparam logic [1:0] MODE_PAGE = 2'b10;

    // Frame phases.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_OPCODE,
        PH_ADDR_HI,
        PH_ADDR_LO,
        PH_DATA,
        PH_STATUS_RD,
        PH_STATUS_WR,
        PH_SKIP
    } phase_t;

    // Request from the frame controller to the array.
    typedef struct packed {
        logic                 we;
        logic                 re;
        logic [ADDR_BITS-1:0] addr;
        logic [DATA_BITS-1:0] wdata;
    } mem_req_t;

endpackage

// ===== rtl/ssram_ram.sv =====
// Single-port synchronous RAM with registered read data.
module ssram_ram #(
    parameter int AW = 15,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic          re,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    // Write port and read port share one address; read data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ssram_ctrl.sv =====
// Frame controller: opcode and address decode, pointer stepping and status register.
module ssram_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic [1:0]                operation,
    input  logic [7:0]                mosi_byte,
    output ssram_pkg::mem_req_t       mem_req,
    output logic [7:0]                miso_value,
    output logic                      use_ram
);
    import ssram_pkg::*;

    phase_t               phase_reg, phase_next;
    logic                 cmd_read_reg, cmd_read_next;
    logic [ADDR_BITS-1:0] pointer_reg, pointer_next;
    logic                 single_done_reg, single_done_next;
    logic [1:0]           mode_reg, mode_next;
    logic                 hold_reg, hold_next;

    logic [15:0]          addr_hi_wide;
    logic [15:0]          addr_lo_wide;
    logic [PAGE_BITS-1:0] page_off_inc;
    logic [ADDR_BITS-1:0] pointer_step;

    // Address byte placement and pointer advance.
    always_comb
    begin
        addr_hi_wide = {mosi_byte, 8'h00};
        addr_lo_wide = {8'h00, mosi_byte};
        page_off_inc = pointer_reg[PAGE_BITS-1:0] + 1'b1;
        if (mode_reg == MODE_PAGE)
        begin
            pointer_step = {pointer_reg[ADDR_BITS-1:PAGE_BITS], page_off_inc};
        end
        else
        begin
            pointer_step = pointer_reg + 1'b1;
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            cmd_read_reg    <= 1'b0;
            pointer_reg     <= '0;
            single_done_reg <= 1'b0;
            mode_reg        <= MODE_BYTE;
            hold_reg        <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            cmd_read_reg    <= cmd_read_next;
            pointer_reg     <= pointer_next;
            single_done_reg <= single_done_next;
            mode_reg        <= mode_next;
            hold_reg        <= hold_next;
        end
    end

    // Next state, array request and answer byte for one event.
    always_comb
    begin
        phase_next       = phase_reg;
        cmd_read_next    = cmd_read_reg;
        pointer_next     = pointer_reg;
        single_done_next = single_done_reg;
        mode_next        = mode_reg;
        hold_next        = hold_reg;
        mem_req.we       = 1'b0;
        mem_req.re       = 1'b0;
        mem_req.addr     = pointer_reg;
        mem_req.wdata    = mosi_byte;
        miso_value       = 8'h00;
        use_ram          = 1'b0;

        if (step)
        begin
            unique case (operation)
                OP_SELECT:
                begin
                    phase_next       = PH_OPCODE;
                    cmd_read_next    = 1'b0;
                    single_done_next = 1'b0;
                end
                OP_DESELECT:
                begin
                    phase_next = PH_IDLE;
                end
                OP_XFER:
                begin
                    unique case (phase_reg)
                        PH_OPCODE:
                        begin
                            cmd_read_next = (mosi_byte == OPC_READ);
                            if (mosi_byte == OPC_READ || mosi_byte == OPC_WRITE)
                            begin
                                phase_next = PH_ADDR_HI;
                            end
                            else if (mosi_byte == OPC_RDSR)
                            begin
                                phase_next = PH_STATUS_RD;
                            end
                            else if (mosi_byte == OPC_WRSR)
                            begin
                                phase_next = PH_STATUS_WR;
                            end
                            else
                            begin
                                phase_next = PH_SKIP;
                            end
                        end
                        PH_ADDR_HI:
                        begin
                            pointer_next = addr_hi_wide[ADDR_BITS-1:0];
                            phase_next   = PH_ADDR_LO;
                        end
                        PH_ADDR_LO:
                        begin
                            pointer_next = pointer_reg | addr_lo_wide[ADDR_BITS-1:0];
                            phase_next   = PH_DATA;
                        end
                        PH_DATA:
                        begin
                            if (single_done_reg)
                            begin
                                phase_next = PH_SKIP;
                            end
                            else
                            begin
                                mem_req.re = cmd_read_reg;
                                mem_req.we = !cmd_read_reg;
                                use_ram    = cmd_read_reg;
                                if (mode_reg == MODE_SEQ || mode_reg == MODE_PAGE)
                                begin
                                    pointer_next = pointer_step;
                                end
                                else
                                begin
                                    single_done_next = 1'b1;
                                    phase_next       = PH_SKIP;
                                end
                            end
                        end
                        PH_STATUS_RD:
                        begin
                            miso_value = {mode_reg, 5'b00000, hold_reg};
                        end
                        PH_STATUS_WR:
                        begin
                            mode_next  = mosi_byte[7:6];
                            hold_next  = mosi_byte[0];
                            phase_next = PH_SKIP;
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

endmodule

// ===== rtl/spi_serial_sram_slave_unit.sv =====
// Top level of the serial SRAM slave: handshakes, answer register and the array.
// Latency: the answer word is valid in the cycle after its event word is accepted.
// Throughput: one event word per cycle while out_ready is high; one array access per event.
// A read's data comes straight from the array's read register, which holds while stalled.
// Reset clears the frame state, pointer and status register; the array is not cleared.
module spi_serial_sram_slave_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] operation,
    input  logic [7:0] mosi_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] miso_byte
);
    import ssram_pkg::*;

    logic       step;
    mem_req_t   mem_req;
    logic [7:0] miso_value;
    logic       use_ram;
    logic [7:0] ram_rdata;
    logic       out_valid_reg, out_valid_next;
    logic       use_ram_reg;
    logic [7:0] miso_reg;

    // Take a new word whenever the answer slot is empty or being emptied.
    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    ssram_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .operation  (operation),
        .mosi_byte  (mosi_byte),
        .mem_req    (mem_req),
        .miso_value (miso_value),
        .use_ram    (use_ram)
    );

    ssram_ram #(
        .AW (ADDR_BITS),
        .DW (DATA_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .re    (mem_req.re),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (ram_rdata)
    );

    // Answer slot valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Answer payload, loaded with each accepted word.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            miso_reg    <= miso_value;
            use_ram_reg <= use_ram;
        end
    end

    assign out_valid = out_valid_reg;
    assign miso_byte = use_ram_reg ? ram_rdata : miso_reg;

    // Every accepted word leaves an answer waiting in the next cycle.
    a_step_answers: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid)
        else $error("accepted word produced no answer");

    // The single array port never reads and writes in the same cycle.
    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.we && mem_req.re))
        else $error("array read and write in one cycle");

    // Select and deselect events are answered with zero.
    a_ctrl_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (step && operation != OP_XFER) |=> (miso_byte == 8'h00))
        else $error("nonzero answer to a select or deselect");

endmodule
